// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, codes and helpers of the hex record parser
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_HEADER,
    PH_DATA,
    PH_CHECKSUM,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_OK,
    KIND_MISMATCH,
    KIND_NOT_DATA,
    KIND_NO_COLON,
    KIND_MALFORMED
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  high_nibble;
    logic        nibble_pending;
    logic [1:0]  hdr_idx;
    logic [7:0]  count_field;
    logic [7:0]  bytes_left;
    logic [15:0] start_addr;
    logic [15:0] next_addr;
    logic [7:0]  byte_sum;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic [7:0]  record_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t hex_digit(logic [7:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.ok  = 1'b1;
      d.val = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

// ===== design/hrp_step.sv =====
// ----------------------------------------------------------------------------
// hrp_step
// per-character state update and result selection of the hex record parser
// ----------------------------------------------------------------------------
module hrp_step (
  input  hrp_pkg::state_t  state_i,
  input  logic [7:0]       char_i,
  output hrp_pkg::state_t  state_o,
  output logic             res_vld_o,
  output hrp_pkg::result_t res_o
);

  hrp_pkg::digit_t dig;
  logic [7:0]      byte_b;
  logic [7:0]      sum_add;
  logic [7:0]      expected;
  logic [7:0]      bytes_dec;

  assign dig       = hrp_pkg::hex_digit(char_i);
  assign byte_b    = {state_i.high_nibble, dig.val};
  assign sum_add   = state_i.byte_sum + byte_b;
  assign expected  = 8'h00 - state_i.byte_sum;
  assign bytes_dec = state_i.bytes_left - 8'd1;

  always_comb begin
    state_o   = state_i;
    res_vld_o = 1'b0;
    res_o     = '{kind: hrp_pkg::KIND_DATA, address: 16'h0000, value: 8'h00,
                  record_length: 8'h00};
    if (char_i == hrp_pkg::CHAR_NEWLINE) begin
      state_o.phase = hrp_pkg::PH_LINE_START;
      unique case (state_i.phase)
        hrp_pkg::PH_LINE_START: begin
          res_vld_o  = 1'b1;
          res_o.kind = hrp_pkg::KIND_NO_COLON;
        end
        hrp_pkg::PH_HEADER, hrp_pkg::PH_DATA, hrp_pkg::PH_CHECKSUM: begin
          res_vld_o           = 1'b1;
          res_o.kind          = hrp_pkg::KIND_MALFORMED;
          res_o.address       = state_i.start_addr;
          res_o.record_length = state_i.count_field;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state_i.phase)
        hrp_pkg::PH_LINE_START: begin
          if (char_i == hrp_pkg::CHAR_COLON) begin
            state_o       = '0;
            state_o.phase = hrp_pkg::PH_HEADER;
          end else begin
            state_o.phase = hrp_pkg::PH_SKIP;
            res_vld_o     = 1'b1;
            res_o.kind    = hrp_pkg::KIND_NO_COLON;
          end
        end
        hrp_pkg::PH_HEADER, hrp_pkg::PH_DATA, hrp_pkg::PH_CHECKSUM: begin
          if (!dig.ok) begin
            state_o.phase       = hrp_pkg::PH_SKIP;
            res_vld_o           = 1'b1;
            res_o.kind          = hrp_pkg::KIND_MALFORMED;
            res_o.address       = state_i.start_addr;
            res_o.record_length = state_i.count_field;
          end else if (!state_i.nibble_pending) begin
            state_o.high_nibble    = dig.val;
            state_o.nibble_pending = 1'b1;
          end else begin
            state_o.nibble_pending = 1'b0;
            if (state_i.phase == hrp_pkg::PH_HEADER) begin
              state_o.byte_sum = sum_add;
              state_o.hdr_idx  = state_i.hdr_idx + 2'd1;
              unique case (state_i.hdr_idx)
                2'd0: state_o.count_field = byte_b;
                2'd1: state_o.start_addr  = {byte_b, 8'h00};
                2'd2: begin
                  state_o.start_addr = {state_i.start_addr[15:8], byte_b};
                  state_o.next_addr  = {state_i.start_addr[15:8], byte_b};
                end
                default: begin
                  state_o.hdr_idx = state_i.hdr_idx;
                  if (byte_b != 8'h00) begin
                    state_o.phase       = hrp_pkg::PH_SKIP;
                    res_vld_o           = 1'b1;
                    res_o.kind          = hrp_pkg::KIND_NOT_DATA;
                    res_o.address       = state_i.start_addr;
                    res_o.record_length = state_i.count_field;
                  end else begin
                    state_o.bytes_left = state_i.count_field;
                    state_o.phase      = (state_i.count_field == 8'h00) ?
                                         hrp_pkg::PH_CHECKSUM : hrp_pkg::PH_DATA;
                  end
                end
              endcase
            end else if (state_i.phase == hrp_pkg::PH_DATA) begin
              state_o.byte_sum    = sum_add;
              state_o.next_addr   = state_i.next_addr + 16'd1;
              state_o.bytes_left  = bytes_dec;
              if (bytes_dec == 8'h00) begin
                state_o.phase = hrp_pkg::PH_CHECKSUM;
              end
              res_vld_o           = 1'b1;
              res_o.kind          = hrp_pkg::KIND_DATA;
              res_o.address       = state_i.next_addr;
              res_o.value         = byte_b;
              res_o.record_length = state_i.count_field;
            end else begin
              state_o.phase       = hrp_pkg::PH_DONE;
              res_vld_o           = 1'b1;
              res_o.address       = state_i.start_addr;
              res_o.record_length = state_i.count_field;
              if (byte_b == expected) begin
                res_o.kind  = hrp_pkg::KIND_OK;
              end else begin
                res_o.kind  = hrp_pkg::KIND_MISMATCH;
                res_o.value = expected;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// hex_record_parser
// decodes hex record text one character per request into data bytes and
// per-record status
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   [7:0] char                              -
// m_axis   out  [15:0] address [23:16] value            [2:0] kind
//               [31:24] record length
//
// one character per clock; each request updates the parser state in the
// cycle it is taken and its result, if any, lands in the output register
// new requests are taken while the output register is empty or drained
// a stall on m_axis holds the output register and stops s_axis
// rst_ni clears the parser to line start and empties the output register
// ----------------------------------------------------------------------------
module hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // address, value, record length
  output logic [2:0]  m_axis_tuser_o    // kind
);

  hrp_pkg::state_t  state_q, state_d;
  hrp_pkg::result_t res_q, res_d;
  logic             out_vld_q;
  logic             step_vld;
  logic             take;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  hrp_step u_step (
    .state_i   (state_q),
    .char_i    (s_axis_tdata_i),
    .state_o   (state_d),
    .res_vld_o (step_vld),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= state_d;
      end
      if (take) begin
        out_vld_q <= step_vld;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && step_vld) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.record_length, res_q.value, res_q.address};
  assign m_axis_tuser_o  = res_q.kind;

`ifndef SYNTH
  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == hrp_pkg::PH_DATA |-> state_q.bytes_left != 8'h00)
    else $error("data phase with no bytes left");

  a_newline_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && s_axis_tdata_i == hrp_pkg::CHAR_NEWLINE
    |=> state_q.phase == hrp_pkg::PH_LINE_START)
    else $error("newline did not return to line start");

  a_no_colon_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == hrp_pkg::KIND_NO_COLON
    |-> m_axis_tdata_o == 32'h0)
    else $error("no-colon status with nonzero payload");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(state_q))
    else $error("state moved while output stalled");
`endif

endmodule

// ===== verif/hrp_checker.sv =====
// ----------------------------------------------------------------------------
// hrp_checker
// watches both stream channels of the hex record parser, decodes every
// accepted character with its own parser state and compares each result
// field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module hrp_checker
  import hrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // char
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // address, value, record length
  input  logic [2:0]  m_axis_tuser_i,   // kind
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e      phase_q;
  logic [3:0]  hi_nib;
  logic        nib_wait;
  logic [1:0]  hdr_pos;
  logic [7:0]  rec_len;
  logic [7:0]  data_left;
  logic [7:0]  csum;
  logic [15:0] base_addr;
  logic [15:0] byte_addr;
  result_t     expected_q[$];
  int          errors = 0;

  task automatic clear_record();
    hi_nib    = 4'h0;
    nib_wait  = 1'b0;
    hdr_pos   = 2'd0;
    rec_len   = 8'h00;
    data_left = 8'h00;
    csum      = 8'h00;
    base_addr = 16'h0000;
    byte_addr = 16'h0000;
  endtask

  task automatic queue_result(kind_e k, logic [15:0] a, logic [7:0] v, logic [7:0] len);
    result_t r;
    r.kind          = k;
    r.address       = a;
    r.value         = v;
    r.record_length = len;
    expected_q.push_back(r);
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [7:0] d8;
    logic [3:0] nib;
    logic       is_hex;
    logic [7:0] b;
    logic [7:0] want;
    if (c == CHAR_NEWLINE) begin
      if (phase_q == PH_LINE_START) begin
        queue_result(KIND_NO_COLON, 16'h0000, 8'h00, 8'h00);
      end else if (phase_q == PH_HEADER || phase_q == PH_DATA || phase_q == PH_CHECKSUM) begin
        queue_result(KIND_MALFORMED, base_addr, 8'h00, rec_len);
      end
      phase_q = PH_LINE_START;
      return;
    end
    case (phase_q)
      PH_LINE_START: begin
        if (c == CHAR_COLON) begin
          clear_record();
          phase_q = PH_HEADER;
        end else begin
          phase_q = PH_SKIP;
          queue_result(KIND_NO_COLON, 16'h0000, 8'h00, 8'h00);
        end
      end
      PH_HEADER, PH_DATA, PH_CHECKSUM: begin
        is_hex = 1'b1;
        d8     = c - 8'h30;
        if (c >= 8'h41 && c <= 8'h46) begin
          d8 = c - 8'h37;
        end else if (c < 8'h30 || c > 8'h39) begin
          is_hex = 1'b0;
        end
        nib = d8[3:0];
        if (!is_hex) begin
          phase_q = PH_SKIP;
          queue_result(KIND_MALFORMED, base_addr, 8'h00, rec_len);
        end else if (!nib_wait) begin
          hi_nib   = nib;
          nib_wait = 1'b1;
        end else begin
          nib_wait = 1'b0;
          b        = {hi_nib, nib};
          case (phase_q)
            PH_HEADER: begin
              csum = csum + b;
              case (hdr_pos)
                2'd0: rec_len = b;
                2'd1: base_addr = {b, 8'h00};
                2'd2: begin
                  base_addr[7:0] = b;
                  byte_addr      = base_addr;
                end
                default: begin
                  if (b != 8'h00) begin
                    phase_q = PH_SKIP;
                    queue_result(KIND_NOT_DATA, base_addr, 8'h00, rec_len);
                  end else begin
                    data_left = rec_len;
                    phase_q   = (rec_len == 8'h00) ? PH_CHECKSUM : PH_DATA;
                  end
                end
              endcase
              if (hdr_pos != 2'd3) hdr_pos = hdr_pos + 2'd1;
            end
            PH_DATA: begin
              queue_result(KIND_DATA, byte_addr, b, rec_len);
              csum      = csum + b;
              byte_addr = byte_addr + 16'd1;
              data_left = data_left - 8'd1;
              if (data_left == 8'h00) phase_q = PH_CHECKSUM;
            end
            default: begin
              want    = 8'h00 - csum;
              phase_q = PH_DONE;
              if (b == want) queue_result(KIND_OK, base_addr, 8'h00, rec_len);
              else queue_result(KIND_MISMATCH, base_addr, want, rec_len);
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected result, expected none, actual kind %0d data %h",
               $time, m_axis_tuser_i, m_axis_tdata_i);
      return;
    end
    want = expected_q.pop_front();
    compare_field("kind", 16'(want.kind), 16'(m_axis_tuser_i));
    compare_field("address", want.address, m_axis_tdata_i[15:0]);
    compare_field("value", 16'(want.value), 16'(m_axis_tdata_i[23:16]));
    compare_field("record length", 16'(want.record_length), 16'(m_axis_tdata_i[31:24]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = PH_LINE_START;
      clear_record();
      expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i) decode_char(s_axis_tdata_i);
    end
    fail_count_o <= errors;
    pending_o    <= expected_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives hex record text into the parser: a directed set of lines for the
// corner cases, then random well-formed, corrupted and noise lines, with
// random idle bursts on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;

  localparam int         CHAR_TARGET = 2000;
  localparam int         QUIET_FROM  = 1700;
  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  logic        clk_i  = 1'b0;
  logic        rst_n  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;
  int          fail_count;
  int          pending;
  int          cycle_count  = 0;
  int          chars_sent   = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  logic [7:0]  line_buf[$];

  hex_record_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  hrp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  function automatic int idle_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 50;
    endcase
  endfunction

  task automatic push_hex(logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic build_record(logic [7:0] cnt, logic [15:0] addr, logic [7:0] rtype,
                              logic sum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    line_buf.push_back(CHAR_COLON);
    sum = cnt + addr[15:8] + addr[7:0] + rtype;
    push_hex(cnt);
    push_hex(addr[15:8]);
    push_hex(addr[7:0]);
    push_hex(rtype);
    for (int i = 0; i < cnt; i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      push_hex(b);
    end
    sum = 8'h00 - sum;
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    push_hex(sum);
  endtask

  task automatic send_char(logic [7:0] c);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic random_line();
    int          sel;
    int          pos;
    logic [7:0]  cnt;
    logic [15:0] addr;
    sel  = $urandom_range(0, 99);
    cnt  = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(17, 255))
                                        : 8'($urandom_range(0, 16));
    addr = ($urandom_range(0, 7) == 0) ? 16'hFFF8 + 16'($urandom_range(0, 7))
                                       : 16'($urandom_range(0, 65535));
    if (sel < 55) begin
      build_record(cnt, addr, 8'h00, $urandom_range(0, 5) != 0);
    end else if (sel < 65) begin
      build_record(cnt, addr, 8'($urandom_range(1, 255)), 1'b1);
    end else if (sel < 80) begin
      build_record(cnt, addr, 8'h00, 1'b1);
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf[pos] = 8'($urandom_range(0, 255));
        1: while (line_buf.size() > pos) void'(line_buf.pop_back());
        default: line_buf.insert(pos, 8'h61 + 8'($urandom_range(0, 5)));
      endcase
    end else if (sel < 88) begin
      if ($urandom_range(0, 1) == 0) line_buf.push_back(CHAR_COLON);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 1) == 0) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        else line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      build_record(cnt, addr, 8'h00, 1'b1);
      if ($urandom_range(0, 1) == 0) line_buf.push_back(CHAR_CR);
      repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    line_buf.push_back(CHAR_NEWLINE);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_ready <= 1'b1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed lines
    src_idle_pct = 10;
    snk_idle_pct = 10;
    push_text("\n");
    push_text("HELLO\n");
    push_text(":00FFFF0002\n");
    build_record(8'd2, 16'hFFFF, 8'h00, 1'b1);
    push_text("\n");
    push_text(":020000000000FFFF\n");
    build_record(8'd255, 16'h1234, 8'h00, 1'b1);
    push_text("\n");
    build_record(8'd3, 16'hABCD, 8'h00, 1'b0);
    push_text("\n");
    push_text(":00000001FF\n");
    push_text(":02000004FFFFFC\n");
    push_text(":10abcd\n");
    push_text(":0300\n");
    push_text(":\n");
    push_text("::\n");
    push_text(":0G\n");
    push_text(":0100000011\n");
    push_text(":01000000112\n");
    push_text(":01000000");
    line_buf.push_back(CHAR_CR);
    push_text("\n");
    push_text(":0000000000 :ZZ");
    line_buf.push_back(CHAR_CR);
    push_text("\n");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    push_text("\n");
    send_line();

    // random lines
    while (chars_sent < CHAR_TARGET) begin
      if (chars_sent >= QUIET_FROM) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        src_idle_pct = idle_odds();
        snk_idle_pct = idle_odds();
      end
      random_line();
      send_line();
    end
    s_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hrp_pkg.sv
design/hrp_step.sv
design/hex_record_parser.sv
verif/hrp_checker.sv
verif/testbench.sv
